>>> rtl/d2p_pkg.sv
package d2p_pkg;

  // Frame limits
  localparam int unsigned MAX_IMAGE_WIDTH  = 4096;
  localparam int unsigned MAX_IMAGE_HEIGHT = 4096;

  // Channel widths
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_COL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_ROW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd5;

  // Item kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Pose words: rotation 0..8 row-major, translation from COEF_TRANS
  localparam int unsigned NUM_COEF   = 12;
  localparam int unsigned COEF_TRANS = 9;
  localparam int unsigned COEF_IDX_W = 4;

  // Divider geometry: 32 quotient bits, divisor up to 59 bits
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DVS_W     = 59;
  localparam int unsigned NUM_W     = 96;

  // Q2.30 rounding constant for the rotation sums
  localparam logic signed [66:0] ROUND_HALF = 67'sd536870912;

  typedef struct packed {
    logic [31:0] center_col;
    logic [31:0] center_row;
    logic [31:0] focal_col;
    logic [31:0] focal_row;
    logic [31:0] baseline;
    logic        mode;
  } cfg_t;

  // Sideband that travels with every beat
  typedef struct packed {
    logic                  vld;
    logic                  pix;
    logic                  load;
    logic [COEF_IDX_W-1:0] cidx;
    logic [31:0]           cval;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic [2:0]            neg;
  } meta_t;

  typedef struct packed {
    logic             ovf;
    logic [DVS_W-1:0] rem;
    logic [31:0]      nlo;
    logic [31:0]      quo;
    logic [DVS_W-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    meta_t           meta;
    div_lane_t [2:0] lane;
  } div_pipe_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } point_t;

endpackage

>>> rtl/d2p_front.sv
module d2p_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_tvalid,
  input  logic [d2p_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  d2p_pkg::cfg_t                cfg,
  output d2p_pkg::div_pipe_t           dout
);
  import d2p_pkg::*;

  // Unpack the beat
  logic [COEF_IDX_W-1:0] cidx;
  logic [31:0]           cval;
  logic [11:0]           row;
  logic [11:0]           col;
  logic [15:0]           disp;

  assign cidx = in_tdata[3:0];
  assign cval = in_tdata[35:4];
  assign row  = in_tdata[47:36];
  assign col  = in_tdata[59:48];
  assign disp = in_tdata[75:60];

  // Stage A: offsets from the principal point, sign and magnitude
  logic signed [32:0] dc;
  logic signed [32:0] dr;
  logic               bneg;
  logic [31:0]        magb;
  meta_t              a_meta_nxt;
  meta_t              a_meta_r;
  logic [31:0]        a_magdc_r;
  logic [31:0]        a_magdr_r;
  logic [31:0]        a_magb_r;
  logic [14:0]        a_disp_r;

  assign dc   = $signed({1'b0, cfg.center_col}) - $signed({5'b0, col, 16'b0});
  assign dr   = $signed({1'b0, cfg.center_row}) - $signed({5'b0, row, 16'b0});
  assign bneg = cfg.baseline[31];
  assign magb = bneg ? (~cfg.baseline + 32'd1) : cfg.baseline;

  always_comb begin
    a_meta_nxt       = '0;
    a_meta_nxt.vld   = in_tvalid;
    a_meta_nxt.pix   = (in_tuser == ACT_PIXEL) && !disp[15] && (disp != 16'd0) &&
                       (32'(row) < MAX_IMAGE_HEIGHT) && (32'(col) < MAX_IMAGE_WIDTH);
    a_meta_nxt.load  = (in_tuser == ACT_LOAD) && (32'(cidx) < NUM_COEF);
    a_meta_nxt.cidx  = cidx;
    a_meta_nxt.cval  = cval;
    a_meta_nxt.blue  = in_tdata[83:76];
    a_meta_nxt.green = in_tdata[91:84];
    a_meta_nxt.red   = in_tdata[99:92];
    a_meta_nxt.neg   = {bneg, (dr[32] ^ cfg.mode) ^ bneg, (dc[32] ^ cfg.mode) ^ bneg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_meta_r.vld <= 1'b0;
    end else if (en) begin
      a_meta_r  <= a_meta_nxt;
      a_magdc_r <= dc[32] ? 32'(-dc) : dc[31:0];
      a_magdr_r <= dr[32] ? 32'(-dr) : dr[31:0];
      a_magb_r  <= magb;
      a_disp_r  <= disp[14:0];
    end
  end

  // Stage B: first products and the divisor base
  logic [31:0] fr;
  meta_t       b_meta_r;
  logic [63:0] b_m0_r;
  logic [63:0] b_m2_r;
  logic [63:0] b_mdrf_r;
  logic [31:0] b_magb_r;
  logic [46:0] b_dv_r;
  logic [14:0] b_disp_r;
  logic [63:0] b_m0_nxt;
  logic [63:0] b_m2_nxt;
  logic [63:0] b_mdrf_nxt;
  logic [46:0] b_dv_nxt;

  assign fr         = (cfg.focal_row == 32'd0) ? 32'd1 : cfg.focal_row;
  assign b_m0_nxt   = a_magdc_r * a_magb_r;
  assign b_m2_nxt   = cfg.focal_col * a_magb_r;
  assign b_mdrf_nxt = a_magdr_r * cfg.focal_col;
  assign b_dv_nxt   = a_disp_r * fr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_meta_r.vld <= 1'b0;
    end else if (en) begin
      b_meta_r <= a_meta_r;
      b_m0_r   <= b_m0_nxt;
      b_m2_r   <= b_m2_nxt;
      b_mdrf_r <= b_mdrf_nxt;
      b_magb_r <= a_magb_r;
      b_dv_r   <= b_dv_nxt;
      b_disp_r <= a_disp_r;
    end
  end

  // Stage C: wide vertical product in two halves
  meta_t       c_meta_r;
  logic [63:0] c_m0_r;
  logic [63:0] c_m2_r;
  logic [63:0] c_pplo_r;
  logic [63:0] c_pphi_r;
  logic [46:0] c_dv_r;
  logic [14:0] c_disp_r;
  logic [63:0] c_pplo_nxt;
  logic [63:0] c_pphi_nxt;

  assign c_pplo_nxt = b_mdrf_r[31:0] * b_magb_r;
  assign c_pphi_nxt = b_mdrf_r[63:32] * b_magb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_meta_r.vld <= 1'b0;
    end else if (en) begin
      c_meta_r <= b_meta_r;
      c_m0_r   <= b_m0_r;
      c_m2_r   <= b_m2_r;
      c_pplo_r <= c_pplo_nxt;
      c_pphi_r <= c_pphi_nxt;
      c_dv_r   <= b_dv_r;
      c_disp_r <= b_disp_r;
    end
  end

  // Stage D: combine halves, scale divisors by 4096
  // (vertical lane divides by disparity times focal row, the others by disparity)
  meta_t            d_meta_r;
  logic [NUM_W-1:0] d_num_r [3];
  logic [DVS_W-1:0] d_dvs_r;
  logic [DVS_W-1:0] d_dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_meta_r.vld <= 1'b0;
    end else if (en) begin
      d_meta_r   <= c_meta_r;
      d_num_r[0] <= {32'b0, c_m0_r};
      d_num_r[1] <= {32'b0, c_pplo_r} + {c_pphi_r, 32'b0};
      d_num_r[2] <= {32'b0, c_m2_r};
      d_dvs_r    <= {c_dv_r, 12'b0};
      d_dvd_r    <= {32'b0, c_disp_r, 12'b0};
    end
  end

  // Stage E: overflow test (quotient of 2^32 or more) and divider seed
  div_pipe_t        e_pipe_nxt;
  div_pipe_t        e_pipe_r;
  logic [DVS_W-1:0] lane_dvs;

  always_comb begin
    e_pipe_nxt.meta = d_meta_r;
    lane_dvs        = d_dvd_r;
    for (int k = 0; k < 3; k++) begin
      lane_dvs = (k == 1) ? d_dvs_r : d_dvd_r;
      e_pipe_nxt.lane[k].ovf = d_num_r[k][NUM_W-1:32] >= {5'b0, lane_dvs};
      e_pipe_nxt.lane[k].rem = d_num_r[k][DVS_W+31:32];
      e_pipe_nxt.lane[k].nlo = d_num_r[k][31:0];
      e_pipe_nxt.lane[k].quo = 32'd0;
      e_pipe_nxt.lane[k].dvs = lane_dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_pipe_r.meta.vld <= 1'b0;
    end else if (en) begin
      e_pipe_r <= e_pipe_nxt;
    end
  end

  assign dout = e_pipe_r;

endmodule

>>> rtl/d2p_divider.sv
module d2p_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  d2p_pkg::div_pipe_t din,
  output d2p_pkg::div_pipe_t dout
);
  import d2p_pkg::*;

  div_pipe_t stg_r   [DIV_STEPS];
  div_pipe_t stg_nxt [DIV_STEPS];

  // One restoring step per stage, three lanes side by side
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    div_pipe_t      src;
    logic [DVS_W:0] trial [3];
    logic [2:0]     ge;

    if (s == 0) begin : g_first
      assign src = din;
    end else begin : g_next
      assign src = stg_r[s-1];
    end

    always_comb begin
      stg_nxt[s] = src;
      for (int k = 0; k < 3; k++) begin
        trial[k] = {src.lane[k].rem, src.lane[k].nlo[31]};
        ge[k]    = trial[k] >= {1'b0, src.lane[k].dvs};
        stg_nxt[s].lane[k].rem = ge[k] ? DVS_W'(trial[k] - {1'b0, src.lane[k].dvs})
                                       : trial[k][DVS_W-1:0];
        stg_nxt[s].lane[k].nlo = {src.lane[k].nlo[30:0], 1'b0};
        stg_nxt[s].lane[k].quo = {src.lane[k].quo[30:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        stg_r[s].meta.vld <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign dout = stg_r[DIV_STEPS-1];

endmodule

>>> rtl/d2p_rotate.sv
module d2p_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  d2p_pkg::div_pipe_t din,
  input  logic               mode,
  output logic               p_vld,
  output d2p_pkg::point_t    p_data
);
  import d2p_pkg::*;

  // Saturate a quotient magnitude with its sign to Q16.16
  function automatic logic [31:0] sat_quo(logic ovf, logic [31:0] q, logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : (~q + 32'd1);
    end else begin
      res = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return res;
  endfunction

  // Saturate a 37-bit signed value to 32 bits
  function automatic logic [31:0] sat37(logic signed [36:0] v);
    logic [31:0] res;
    if (v > 37'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Pose words; a load beat writes here, in order with the pixels
  logic [31:0] coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= 32'd0;
      end
    end else if (en && din.meta.vld && din.meta.load) begin
      coef_r[din.meta.cidx] <= din.meta.cval;
    end
  end

  // Stage S: camera coordinates minus translation
  logic [31:0]        cam [3];
  logic signed [32:0] s_diff_nxt [3];
  logic signed [32:0] s_diff_r   [3];
  meta_t              s_meta_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cam[k] = sat_quo(din.lane[k].ovf, din.lane[k].quo, din.meta.neg[k]);
      s_diff_nxt[k] = $signed({cam[k][31], cam[k]}) -
                      $signed({coef_r[COEF_TRANS+k][31], coef_r[COEF_TRANS+k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_meta_r.vld <= 1'b0;
    end else if (en) begin
      s_meta_r <= din.meta;
      s_diff_r <= s_diff_nxt;
    end
  end

  // Stage M: nine rotation products
  logic signed [64:0] m_prod_nxt [3][3];
  logic signed [64:0] m_prod_r   [3][3];
  meta_t              m_meta_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m_prod_nxt[r][k] = $signed(coef_r[r*3+k]) * s_diff_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_meta_r.vld <= 1'b0;
    end else if (en) begin
      m_meta_r <= s_meta_r;
      m_prod_r <= m_prod_nxt;
    end
  end

  // Stage A: row sums with rounding half
  logic signed [66:0] acc_nxt [3];
  logic signed [66:0] acc_r   [3];
  meta_t              acc_meta_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = 67'(m_prod_r[r][0]) + 67'(m_prod_r[r][1]) + 67'(m_prod_r[r][2]) +
                   ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_meta_r.vld <= 1'b0;
    end else if (en) begin
      acc_meta_r <= m_meta_r;
      acc_r      <= acc_nxt;
    end
  end

  // Final: Q16.16, axis order by mode, negate x
  logic [31:0] pnt [3];
  logic [31:0] ax;
  logic [31:0] bx;
  logic [31:0] cx;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pnt[r] = sat37(acc_r[r][66:30]);
    end
    if (mode) begin
      ax = pnt[1];
      bx = pnt[2];
      cx = pnt[0];
    end else begin
      ax = pnt[0];
      bx = pnt[1];
      cx = pnt[2];
    end
    p_data.x     = (ax == 32'h8000_0000) ? 32'h7FFF_FFFF : (~ax + 32'd1);
    p_data.y     = cx;
    p_data.z     = bx;
    p_data.blue  = acc_meta_r.blue;
    p_data.green = acc_meta_r.green;
    p_data.red   = acc_meta_r.red;
  end

  assign p_vld = acc_meta_r.vld && acc_meta_r.pix;

endmodule

>>> rtl/d2p_outbuf.sv
module d2p_outbuf (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           p_vld,
  input  d2p_pkg::point_t                p_data,
  output logic                           en,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [d2p_pkg::OUT_DATA_W-1:0] out_tdata
);
  import d2p_pkg::*;

  logic   out_vld_r;
  point_t out_data_r;
  logic   skid_vld_r;
  point_t skid_data_r;

  // Pipeline moves while the skid slot is empty
  assign en = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (p_vld) begin
      if (!out_vld_r || out_tready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Data path of the output register and skid slot
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (p_vld) begin
      if (!out_vld_r || out_tready) begin
        out_data_r <= p_data;
      end else begin
        skid_data_r <= p_data;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_data_r.red, out_data_r.green, out_data_r.blue,
                       out_data_r.z, out_data_r.y, out_data_r.x};

endmodule

>>> rtl/disparity_to_point_reproject_unit.sv
// Disparity to 3D point reprojection.
// Input stream: one beat per pixel or pose word. in_tuser selects the kind
// (load pose word or process pixel); in_tdata carries index, word, row,
// column, disparity and color. Pose words are applied in stream order, so
// a pixel sees exactly the words loaded ahead of it.
// Output stream: one beat per pixel with positive disparity inside the
// frame, carrying x, y, z in Q16.16 and the color bytes.
// Config port: cfg_index/cfg_data write one register per beat, always
// ready; write it only while the stream is empty.
// Throughput: one beat per clock while the skid slot is empty. Beats pass
// through the front stages, the 32-stage quotient pipeline, the multiply
// and rotation stages and the output register.
// Reset: synchronous, active low; registers take their defaults, pose
// words clear to zero, pipeline empties.
// Stall: a skid slot behind the output register absorbs one beat; in_tready
// drops once a point meets a stalled beat, and the whole pipeline holds.
module disparity_to_point_reproject_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] coef_index, [35:4] coef_value, [47:36] pixel_row,
  // [59:48] pixel_col, [75:60] disparity, [83:76] blue_in,
  // [91:84] green_in, [99:92] red_in, [103:100] zero
  input  logic [d2p_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] point_z,
  // [103:96] blue_out, [111:104] green_out, [119:112] red_out
  output logic [d2p_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [d2p_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);
  import d2p_pkg::*;

  // Configuration registers
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_col <= 32'd0;
      cfg_r.center_row <= 32'd0;
      cfg_r.focal_col  <= 32'd65536;
      cfg_r.focal_row  <= 32'd65536;
      cfg_r.baseline   <= 32'd65536;
      cfg_r.mode       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_COL: cfg_r.center_col <= cfg_data;
        CFG_CENTER_ROW: cfg_r.center_row <= cfg_data;
        CFG_FOCAL_COL:  cfg_r.focal_col  <= cfg_data;
        CFG_FOCAL_ROW:  cfg_r.focal_row  <= cfg_data;
        CFG_BASELINE:   cfg_r.baseline   <= cfg_data;
        CFG_MODE:       cfg_r.mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Datapath
  logic      en;
  div_pipe_t front_out;
  div_pipe_t div_out;
  logic      p_vld;
  point_t    p_data;

  assign in_tready = en;

  d2p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .dout      (front_out)
  );

  d2p_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (front_out),
    .dout  (div_out)
  );

  d2p_rotate u_rotate (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .din    (div_out),
    .mode   (cfg_r.mode),
    .p_vld  (p_vld),
    .p_data (p_data)
  );

  d2p_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .p_vld      (p_vld),
    .p_data     (p_data),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/d2p_checker.sv
module d2p_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [d2p_pkg::IN_DATA_W-1:0]       in_tdata,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [d2p_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [d2p_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [31:0]                         cfg_data
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // Input backpressure only while a result is pending
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending output");

  // Input stalls only after the receiver stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stall without receiver stall");

endmodule

bind disparity_to_point_reproject_unit d2p_checker u_d2p_checker (.*);

>>> tb/sv/tb_disparity_to_point_reproject_unit.sv
`timescale 1ns / 100ps

module tb_disparity_to_point_reproject_unit;
  import d2p_pkg::*;

  // One input item, unpacked
  typedef struct {
    logic        act;
    logic [3:0]  cidx;
    logic [31:0] cval;
    logic [11:0] row;
    logic [11:0] col;
    logic [15:0] disp;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_item_t;

  // Expected points and the block's state as the stream sees it
  class point_scoreboard;
    point_t      pending[$];
    cfg_t        regs;
    logic [31:0] pose[NUM_COEF];
    int          errors;

    function new();
      regs.center_col = 32'd0;
      regs.center_row = 32'd0;
      regs.focal_col  = 32'd65536;
      regs.focal_row  = 32'd65536;
      regs.baseline   = 32'd65536;
      regs.mode       = 1'b0;
      foreach (pose[i]) pose[i] = 32'd0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_CENTER_COL: regs.center_col = data;
        CFG_CENTER_ROW: regs.center_row = data;
        CFG_FOCAL_COL:  regs.focal_col  = data;
        CFG_FOCAL_ROW:  regs.focal_row  = data;
        CFG_BASELINE:   regs.baseline   = data;
        CFG_MODE:       regs.mode       = data[0];
        default: ;
      endcase
    endfunction

    static function logic [127:0] magnitude(logic signed [63:0] v);
      return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    // Truncating divide of a magnitude, sign applied, saturated to 32 bits
    static function logic signed [63:0] scaled_depth(logic [127:0] num, logic [127:0] div,
                                                     bit neg);
      logic [127:0] q;
      q = num / div;
      if (neg) return (q > 128'h8000_0000) ? -64'sh8000_0000 : -$signed(64'(q));
      return (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(64'(q));
    endfunction

    // One rotation row on the translated point, rounded to Q16.16
    function logic signed [63:0] rotated_axis(int r, logic signed [63:0] cam[3]);
      logic signed [127:0] acc, rc, df;
      acc = 128'sd0;
      for (int k = 0; k < 3; k++) begin
        rc = $signed(pose[r*3+k]);
        df = cam[k] - $signed(pose[COEF_TRANS+k]);
        acc += rc * df;
      end
      acc = (acc + 128'sd536870912) >>> 30;
      if (acc > 128'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (acc < -128'sh8000_0000) return -64'sh8000_0000;
      return 64'(acc);
    endfunction

    function void note_input(pixel_item_t it);
      logic signed [63:0] dc, dr, bl, d, a, bb, c;
      logic signed [63:0] cam[3], p[3];
      logic [127:0] div, fr;
      point_t pt;
      if (it.act == ACT_LOAD) begin
        if (it.cidx < NUM_COEF) pose[it.cidx] = it.cval;
        return;
      end
      d = $signed(it.disp);
      if (d <= 0) return;
      dc = $signed({32'd0, regs.center_col}) - $signed({36'd0, it.col, 16'd0});
      dr = $signed({32'd0, regs.center_row}) - $signed({36'd0, it.row, 16'd0});
      if (regs.mode) begin
        dc = -dc;
        dr = -dr;
      end
      bl  = $signed(regs.baseline);
      div = 128'(d) * 128'd4096;
      fr  = (regs.focal_row != 0) ? 128'(regs.focal_row) : 128'd1;
      cam[0] = scaled_depth(magnitude(dc) * magnitude(bl), div, (dc < 0) != (bl < 0));
      cam[1] = scaled_depth(magnitude(dr) * 128'(regs.focal_col) * magnitude(bl), div * fr,
                            (dr < 0) != (bl < 0));
      cam[2] = scaled_depth(128'(regs.focal_col) * magnitude(bl), div, bl < 0);
      for (int r = 0; r < 3; r++) p[r] = rotated_axis(r, cam);
      if (regs.mode) begin
        a = p[1]; bb = p[2]; c = p[0];
      end else begin
        a = p[0]; bb = p[1]; c = p[2];
      end
      // negating the most negative value saturates
      a = (a == -64'sh8000_0000) ? 64'sh7FFF_FFFF : -a;
      pt.x = a[31:0];
      pt.y = c[31:0];
      pt.z = bb[31:0];
      pt.blue  = it.blue;
      pt.green = it.green;
      pt.red   = it.red;
      pending.insert(pending.size(), pt);
    endfunction

    task check_result(logic [OUT_DATA_W-1:0] data);
      point_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %h", data));
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.x)
        report($sformatf("point_x %h want %h", data[31:0], want.x));
      if (data[63:32] !== want.y)
        report($sformatf("point_y %h want %h", data[63:32], want.y));
      if (data[95:64] !== want.z)
        report($sformatf("point_z %h want %h", data[95:64], want.z));
      if (data[103:96] !== want.blue)
        report($sformatf("blue %h want %h", data[103:96], want.blue));
      if (data[111:104] !== want.green)
        report($sformatf("green %h want %h", data[111:104], want.green));
      if (data[119:112] !== want.red)
        report($sformatf("red %h want %h", data[119:112], want.red));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  point_scoreboard sb = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  pressure_req   = 0;
  bit  pressure_done  = 0;
  int  hold_left      = 0;
  longint cycles      = 0;

  disparity_to_point_reproject_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check accepted beats, then pick next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (pressure_req && !pressure_done) begin
      pressure_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task send_item(pixel_item_t it);
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {4'd0, it.red, it.green, it.blue, it.disp, it.col, it.row, it.cval, it.cidx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task load_word(int idx, logic [31:0] val);
    pixel_item_t it;
    it = '{ACT_LOAD, 4'(idx), val, 12'($urandom), 12'($urandom), 16'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom)};
    send_item(it);
  endtask

  task send_pixel(int row, int col, int disp, int b, int g, int r);
    pixel_item_t it;
    it = '{ACT_PIXEL, 4'($urandom), 32'($urandom), 12'(row), 12'(col), 16'(disp),
           8'(b), 8'(g), 8'(r)};
    send_item(it);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Wait for all points, then past the pipeline depth for trailing loads
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task apply_setting(int k);
    logic [31:0] v[6];
    case (k)
      0: v = '{32'd320 << 16, 32'd240 << 16, 32'd700 << 16, 32'd700 << 16, 32'd7864, 32'd0};
      1: v = '{32'd640 << 16, 32'd100 << 16, 32'd900 << 16, 32'd450 << 16, 32'd33000, 32'd1};
      2: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd1};
      3: v = '{32'd0, 32'd0, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'd0};
      default: v = '{$urandom, $urandom, $urandom_range(32'hFFFF_FFFF, 1),
                     $urandom, $urandom, $urandom};
    endcase
    write_reg(CFG_CENTER_COL, v[0]);
    write_reg(CFG_CENTER_ROW, v[1]);
    write_reg(CFG_FOCAL_COL,  v[2]);
    write_reg(CFG_FOCAL_ROW,  v[3]);
    write_reg(CFG_BASELINE,   v[4]);
    write_reg(CFG_MODE,       v[5]);
    cfg_valid <= 1'b0;
  endtask

  // A pose near identity, or a fully random one
  task load_pose(bit wild);
    for (int i = 0; i < NUM_COEF; i++) begin
      if (wild) load_word(i, $urandom);
      else if (i >= COEF_TRANS) load_word(i, 32'($signed($urandom_range(400000)) - 200000));
      else if (i % 4 == 0) load_word(i, 32'h4000_0000 + $urandom_range(4096) - 2048);
      else load_word(i, 32'($signed($urandom_range(8000000)) - 4000000));
    end
  endtask

  task random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      load_word($urandom_range(15), $urandom);
    end else if (pick < 12) begin
      // non-positive disparity, no point expected
      send_pixel($urandom, $urandom, -$signed($urandom_range(32768)),
                 $urandom, $urandom, $urandom);
    end else if (pick < 30) begin
      send_pixel($urandom, $urandom, $urandom_range(32767, 1), $urandom, $urandom, $urandom);
    end else begin
      send_pixel($urandom, $urandom, $urandom_range(2048, 1), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ACT_LOAD;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CENTER_COL;
    cfg_data   = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pixels before any load see the all-zero pose
    send_pixel(0, 0, 16, 0, 0, 0);
    drain();
    apply_setting(0);
    load_pose(0);
    load_word(0, 32'h8000_0000);
    load_word(4, 32'h7FFF_FFFF);
    load_word(12, 32'h1234_5678);
    load_word(15, 32'hFFFF_FFFF);
    send_pixel(0, 0, 1, 255, 255, 255);
    send_pixel(4095, 4095, 32767, 0, 255, 0);
    send_pixel(4095, 0, 16, 255, 0, 255);
    send_pixel(0, 4095, 0, 1, 2, 3);
    send_pixel(100, 100, -1, 4, 5, 6);
    send_pixel(100, 100, -32768, 7, 8, 9);
    send_pixel(2048, 2048, 2, 170, 85, 170);
    drain();
    apply_setting(2);
    load_pose(1);
    send_pixel(0, 0, 1, 85, 170, 85);
    send_pixel(4095, 4095, 1, 1, 1, 1);
    send_pixel(1234, 3000, 32767, 2, 2, 2);
    drain();

    // Random phases over several settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(ph % 6);
      send_idle_pct  = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 29 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 29 : 0;
      if (ph == 4) pressure_req = 1;
      load_pose(ph == 5);
      for (int n = 0; n < 240; n++) begin
        random_item();
        if (n == 120 && $urandom_range(1)) load_pose($urandom_range(1));
      end
      drain();
    end

    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
